// ===== rtl/fcps_pkg.sv =====
package fcps_pkg;

  // Fixed field widths of the request, configuration and result channels
  localparam int FRAME_W    = 16;
  localparam int CHUNK_W    = 3;
  localparam int WORKER_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  // Shared counter: slot reduction steps, exit tasks, render chunks
  localparam int CNT_W      = 4;

  // Request actions
  localparam logic [1:0] ACT_START        = 2'd0;
  localparam logic [1:0] ACT_RENDER_DONE  = 2'd1;
  localparam logic [1:0] ACT_DISPLAY_DONE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd1;

  typedef enum logic [1:0] {
    KIND_RENDER       = 2'd0,
    KIND_DISPLAY      = 2'd1,
    KIND_EXIT_WORKER  = 2'd2,
    KIND_EXIT_DISPLAY = 2'd3
  } task_kind_t;

  // Source of the next result loaded into the output register
  typedef enum logic [2:0] {
    SRC_EMPTY,
    SRC_RENDER,
    SRC_DISPLAY,
    SRC_EXIT_WORKER,
    SRC_EXIT_DISPLAY
  } src_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic set_bit;
    logic check;
    logic clear_deps;
    logic cnt_clr;
    logic cnt_inc;
    logic emit;
    src_t src;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_render;
    logic is_display;
    logic chunk_ok;
    logic mod_done;
    logic queue_go;
    logic exit_go;
    logic disp_go;
    logic disp_more;
    logic worker_last;
    logic worker_zero;
    logic render_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/fcps_datapath.sv =====
module fcps_datapath import fcps_pkg::*; #(
  parameter int CHUNKS     = 8,
  parameter int BUFFERS    = 3,
  parameter int FRAME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [1:0]            in_action,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic [CHUNK_W-1:0]    in_chunk_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_task_kind,
  output logic [FRAME_W-1:0]    out_task_frame,
  output logic [CHUNK_W-1:0]    out_task_chunk,
  output logic                  out_task_valid,
  output logic                  out_last_task
);

  localparam int SLOTS  = 2 * BUFFERS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMP_W  = (FRAME_BITS > FRAME_W) ? FRAME_BITS : FRAME_W;
  localparam int NF_W   = FRAME_W + 1;

  // Reciprocal of the slot count, exact for every frame number
  localparam int     RECIP_SH = FRAME_W + 5;
  localparam int     PROD_W   = FRAME_W + RECIP_SH;
  localparam longint RECIP_L  = ((longint'(1) << RECIP_SH) + longint'(SLOTS) - 1) /
                                longint'(SLOTS);

  localparam logic [SLOT_W:0]   SLOTS_X        = (SLOT_W+1)'(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST      = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] BUF_SLOT       = SLOT_W'(BUFFERS);
  localparam logic [CHUNKS-1:0] FULL           = '1;
  localparam logic [CHUNKS-1:0] ONE            = CHUNKS'(1);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST    = CHUNK_W'(CHUNKS - 1);
  localparam logic [CNT_W-1:0]  CNT_CHUNK_LAST = CNT_W'(CHUNKS - 1);
  localparam logic [CNT_W-1:0]  CNT_MOD_LAST   = CNT_W'(1);
  localparam logic [RECIP_SH-1:0] RECIP        = RECIP_SH'(RECIP_L);
  localparam logic [FRAME_W-1:0] SLOTS_F       = FRAME_W'(SLOTS);

  logic [1:0]            action_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [CHUNK_W-1:0]    chunk_r;
  logic [FRAME_W-1:0]    quot_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [FRAME_W-1:0]    render_frame_r;
  logic                  queue_r;
  logic [FRAME_W-1:0]    frame_total_r;
  logic [WORKER_W-1:0]   worker_count_r;
  logic [CHUNKS-1:0]     render_bits_r  [SLOTS];
  logic [CHUNKS-1:0]     display_bits_r [SLOTS];
  logic [FRAME_BITS-1:0] ptr_frame_r;
  logic [CHUNK_W-1:0]    ptr_chunk_r;
  logic                  out_valid_r;
  task_kind_t            out_kind_r;
  logic [FRAME_W-1:0]    out_frame_r;
  logic [CHUNK_W-1:0]    out_chunk_r;
  logic                  out_task_valid_r;
  logic                  out_last_r;

  logic                  is_render;
  logic [PROD_W-1:0]     prod;
  logic [FRAME_W-1:0]    quot_nxt;
  logic [FRAME_W-1:0]    rem_full;
  logic [SLOT_W-1:0]     slot_nxt;
  logic [SLOT_W-1:0]     inc_slot;
  logic [SLOT_W-1:0]     slot_nf;
  logic [SLOT_W-1:0]     prev_slot;
  logic [SLOT_W-1:0]     back_slot;
  logic [SLOT_W-1:0]     rd_addr;
  logic [NF_W-1:0]       nf;
  logic                  queue_now;
  logic [CHUNKS-1:0]     rbits;
  logic [CHUNKS-1:0]     rsh;
  logic [CHUNKS-1:0]     rsh_next;
  logic                  out_free;

  // Reduce a value below twice the slot count into a slot number
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] v);
    logic [SLOT_W:0] r;
    r = (v >= SLOTS_X) ? (v - SLOTS_X) : v;
    return r[SLOT_W-1:0];
  endfunction

  assign is_render = (action_r == ACT_RENDER_DONE);

  // Quotient by reciprocal multiply, then remainder from the held quotient
  assign prod     = {{RECIP_SH{1'b0}}, frame_r} * {{FRAME_W{1'b0}}, RECIP};
  assign quot_nxt = prod[PROD_W-1:RECIP_SH];
  assign rem_full = frame_r - (quot_r * SLOTS_F);
  assign slot_nxt = rem_full[SLOT_W-1:0];

  // Slots of the next frame and of the two frames it depends on
  assign inc_slot  = is_render ? SLOT_W'(1) : BUF_SLOT;
  assign slot_nf   = wrap_slot({1'b0, slot_r} + {1'b0, inc_slot});
  assign prev_slot = (slot_nf == '0) ? SLOT_LAST : (slot_nf - SLOT_W'(1));
  assign back_slot = wrap_slot({1'b0, slot_nf} + {1'b0, BUF_SLOT});

  assign nf        = {1'b0, frame_r} + (is_render ? NF_W'(1) : NF_W'(BUFFERS));
  assign rd_addr   = cmd.check ? prev_slot : slot_r;
  assign rbits     = render_bits_r[rd_addr];
  assign queue_now = (nf < {1'b0, frame_total_r}) && (rbits == FULL) &&
                     (display_bits_r[back_slot] == FULL);

  // Display pointer lookahead on the event's slot
  assign rsh      = rbits >> ptr_chunk_r;
  assign rsh_next = rbits >> (ptr_chunk_r + CHUNK_W'(1));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    status             = '0;
    status.is_start    = (action_r == ACT_START);
    status.is_render   = is_render;
    status.is_display  = (action_r == ACT_DISPLAY_DONE);
    status.chunk_ok    = ({1'b0, chunk_r} < (CHUNK_W+1)'(CHUNKS));
    status.mod_done    = (cnt_r == CNT_MOD_LAST);
    status.queue_go    = queue_r;
    status.exit_go     = (({1'b0, frame_r} + NF_W'(1)) == {1'b0, frame_total_r}) &&
                         (chunk_r == CHUNK_LAST);
    status.disp_go     = (CMP_W'(ptr_frame_r) == CMP_W'(frame_r)) && rsh[0];
    status.disp_more   = (ptr_chunk_r != CHUNK_LAST) && rsh_next[0];
    status.worker_last = (((CNT_W+1)'(cnt_r) + (CNT_W+1)'(1)) ==
                          (CNT_W+1)'(worker_count_r));
    status.worker_zero = (worker_count_r == '0);
    status.render_last = (cnt_r == CNT_CHUNK_LAST);
    status.out_free    = out_free;
  end

  // Latch the request and run the slot reduction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      frame_r  <= in_frame_number;
      chunk_r  <= in_chunk_index;
      slot_r   <= '0;
    end else if (cmd.mod_step) begin
      quot_r <= quot_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Hold the queue decision and the frame to queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_r        <= 1'b0;
      render_frame_r <= '0;
    end else if (cmd.load) begin
      queue_r        <= 1'b0;
      render_frame_r <= '0;
    end else if (cmd.check) begin
      queue_r        <= queue_now;
      render_frame_r <= nf[FRAME_W-1:0];
    end
  end

  // Advance the shared counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc || cmd.mod_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Completion bitmaps: mark on events, drop dependencies on queueing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        render_bits_r[i]  <= '0;
        display_bits_r[i] <= (i >= BUFFERS) ? FULL : '0;
      end
    end else begin
      if (cmd.set_bit) begin
        if (is_render) begin
          render_bits_r[slot_r] <= render_bits_r[slot_r] | (ONE << chunk_r);
        end else begin
          display_bits_r[slot_r] <= display_bits_r[slot_r] | (ONE << chunk_r);
        end
      end
      if (cmd.clear_deps) begin
        render_bits_r[prev_slot]  <= '0;
        display_bits_r[back_slot] <= '0;
      end
    end
  end

  // Advance the in-order display pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_frame_r <= '0;
      ptr_chunk_r <= '0;
    end else if (cmd.emit && (cmd.src == SRC_DISPLAY)) begin
      if (ptr_chunk_r == CHUNK_LAST) begin
        ptr_chunk_r <= '0;
        ptr_frame_r <= ptr_frame_r + FRAME_BITS'(1);
      end else begin
        ptr_chunk_r <= ptr_chunk_r + CHUNK_W'(1);
      end
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r  <= FRAME_W'(10);
      worker_count_r <= WORKER_W'(4);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_TOTAL:  frame_total_r  <= cfg_data;
        CFG_WORKER_COUNT: worker_count_r <= cfg_data[WORKER_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.last;
      case (cmd.src)
        SRC_RENDER: begin
          out_kind_r       <= KIND_RENDER;
          out_frame_r      <= render_frame_r;
          out_chunk_r      <= cnt_r[CHUNK_W-1:0];
          out_task_valid_r <= 1'b1;
        end
        SRC_DISPLAY: begin
          out_kind_r       <= KIND_DISPLAY;
          out_frame_r      <= frame_r;
          out_chunk_r      <= ptr_chunk_r;
          out_task_valid_r <= 1'b1;
        end
        SRC_EXIT_WORKER: begin
          out_kind_r       <= KIND_EXIT_WORKER;
          out_frame_r      <= '0;
          out_chunk_r      <= '0;
          out_task_valid_r <= 1'b1;
        end
        SRC_EXIT_DISPLAY: begin
          out_kind_r       <= KIND_EXIT_DISPLAY;
          out_frame_r      <= '0;
          out_chunk_r      <= '0;
          out_task_valid_r <= 1'b1;
        end
        default: begin
          out_kind_r       <= KIND_RENDER;
          out_frame_r      <= '0;
          out_chunk_r      <= '0;
          out_task_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_task_kind  = out_kind_r;
  assign out_task_frame = out_frame_r;
  assign out_task_chunk = out_chunk_r;
  assign out_task_valid = out_task_valid_r;
  assign out_last_task  = out_last_r;

endmodule

// ===== rtl/fcps_ctrl.sv =====
module fcps_ctrl import fcps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_SET,
    ST_CHECK,
    ST_DECIDE,
    ST_DISP,
    ST_EXIT_W,
    ST_EXIT_D,
    ST_CLEAR,
    ST_RENDER,
    ST_EMPTY
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Sequence one request through its phases
  always_comb begin
    cmd       = '0;
    cmd.src   = SRC_EMPTY;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_start) begin
          state_nxt = ST_RENDER;
        end else if ((status.is_render || status.is_display) && status.chunk_ok) begin
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_EMPTY;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) begin
          state_nxt = ST_SET;
        end
      end
      ST_SET: begin
        cmd.set_bit = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.is_render) begin
          if (status.disp_go) begin
            state_nxt = ST_DISP;
          end else if (status.queue_go) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_EMPTY;
          end
        end else if (status.exit_go) begin
          state_nxt = status.worker_zero ? ST_EXIT_D : ST_EXIT_W;
        end else if (status.queue_go) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_EMPTY;
        end
      end
      ST_DISP: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_DISPLAY;
          cmd.last = !status.disp_more && !status.queue_go;
          if (status.disp_more) begin
            state_nxt = ST_DISP;
          end else if (status.queue_go) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXIT_W: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_EXIT_WORKER;
          cmd.cnt_inc = 1'b1;
          if (status.worker_last) begin
            state_nxt = ST_EXIT_D;
          end
        end
      end
      ST_EXIT_D: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_EXIT_DISPLAY;
          cmd.last  = !status.queue_go;
          state_nxt = status.queue_go ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clear_deps = 1'b1;
        cmd.cnt_clr    = 1'b1;
        state_nxt      = ST_RENDER;
      end
      ST_RENDER: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_RENDER;
          cmd.cnt_inc = 1'b1;
          cmd.last    = status.render_last;
          if (status.render_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_EMPTY;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/frame_chunk_pipeline_scheduler_top.sv =====
// Flow: start and rejected requests go from decode straight to their results; render-done and
// display-done pass through decode, reciprocal slot reduction, bitmap update, dependency check and
// decision, plus a clear step when a frame is queued and its dependencies cleared.
// Throughput: one result per cycle while out_stall is low, apart from the clear step; the input stays
// stalled until a request has issued all its results, so a new request is taken only after that.
// Reset (rst_n, synchronous, active low) restores bitmaps, display pointer and config defaults.
module frame_chunk_pipeline_scheduler_top import fcps_pkg::*; #(
  parameter int CHUNKS     = 8,
  parameter int BUFFERS    = 3,
  parameter int FRAME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [FRAME_W-1:0]    in_frame_number,
  input  logic [CHUNK_W-1:0]    in_chunk_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_task_kind,
  output logic [FRAME_W-1:0]    out_task_frame,
  output logic [CHUNK_W-1:0]    out_task_chunk,
  output logic                  out_task_valid,
  output logic                  out_last_task
);

  cmd_t    cmd;
  status_t status;

  fcps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fcps_datapath #(
    .CHUNKS     (CHUNKS),
    .BUFFERS    (BUFFERS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_frame_number (in_frame_number),
    .in_chunk_index  (in_chunk_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_task_kind   (out_task_kind),
    .out_task_frame  (out_task_frame),
    .out_task_chunk  (out_task_chunk),
    .out_task_valid  (out_task_valid),
    .out_last_task   (out_last_task)
  );

endmodule

// ===== sim/frame_chunk_pipeline_scheduler_top_tb.sv =====
module frame_chunk_pipeline_scheduler_top_tb import fcps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCHUNK = 8;
  localparam int NBUF = 3;
  localparam int NSLOT = 2 * NBUF;
  localparam logic [NCHUNK-1:0] ALL_CHUNKS = '1;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]         action;
    logic [FRAME_W-1:0] frame;
    logic [CHUNK_W-1:0] chunk;
    bit                 tracked;
  } sched_event_t;

  typedef struct {
    task_kind_t         kind;
    logic [FRAME_W-1:0] frame;
    logic [CHUNK_W-1:0] chunk;
    logic               has_task;
    logic               is_last;
  } sched_task_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = '0;
  logic [FRAME_W-1:0]    in_frame_number = '0;
  logic [CHUNK_W-1:0]    in_chunk_index = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_task_kind;
  logic [FRAME_W-1:0]    out_task_frame;
  logic [CHUNK_W-1:0]    out_task_chunk;
  logic                  out_task_valid;
  logic                  out_last_task;

  frame_chunk_pipeline_scheduler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_frame_number (in_frame_number),
    .in_chunk_index  (in_chunk_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_task_kind   (out_task_kind),
    .out_task_frame  (out_task_frame),
    .out_task_chunk  (out_task_chunk),
    .out_task_valid  (out_task_valid),
    .out_last_task   (out_last_task)
  );

  always #5 clk = ~clk;

  // Scheduler shadow state and configuration
  logic [NCHUNK-1:0] sched_render[NSLOT];
  logic [NCHUNK-1:0] sched_shown[NSLOT];
  int                sched_disp_frame;
  int                sched_disp_chunk;
  int                sched_frame_total;
  int                sched_workers;

  sched_event_t event_queue[$];
  sched_event_t open_jobs[$];
  sched_event_t recent_events[$];
  sched_task_t  due_tasks[$];
  sched_task_t  batch[$];

  sched_event_t cur_event;
  int  gap_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_calm = 1'b0;
  int  rx_hold_reqs = 0;
  int  rx_hold_seen = 0;
  int  rx_hold_left = 0;
  int  rx_stall_left = 0;
  int  cycles = 0;
  int  n_fail = 0;
  int  n_requests = 0;
  int  n_results = 0;
  int  n_cfg = 0;
  int  n_exits = 0;
  int  peak_frame = 0;

  function automatic void add_task(task_kind_t kind, int frame, int chunk);
    sched_task_t t;
    t.kind = kind;
    t.frame = frame[FRAME_W-1:0];
    t.chunk = chunk[CHUNK_W-1:0];
    t.has_task = 1'b1;
    t.is_last = 1'b0;
    batch.push_back(t);
  endfunction

  function automatic void add_render_frame(int frame);
    for (int c = 0; c < NCHUNK; c++) add_task(KIND_RENDER, frame, c);
    if (frame > peak_frame) peak_frame = frame;
  endfunction

  // Work out the tasks one request issues and advance the shadow state
  function automatic void plan_tasks(sched_event_t ev);
    sched_task_t  t;
    sched_event_t job;
    int frame, chunk, slot, dslot, nxt, prv, back;
    frame = int'(ev.frame);
    chunk = int'(ev.chunk);
    slot = frame % NSLOT;
    batch.delete();
    if (ev.action == ACT_START) begin
      add_render_frame(0);
    end else if ((ev.action == ACT_RENDER_DONE || ev.action == ACT_DISPLAY_DONE) &&
                 chunk < NCHUNK) begin
      if (ev.action == ACT_RENDER_DONE) begin
        dslot = sched_disp_frame % NSLOT;
        sched_render[slot][chunk] = 1'b1;
        // Issue display tasks in order while the pointed chunk is rendered
        while (sched_disp_frame == frame && sched_render[dslot][sched_disp_chunk]) begin
          add_task(KIND_DISPLAY, sched_disp_frame, sched_disp_chunk);
          sched_disp_chunk++;
          if (sched_disp_chunk >= NCHUNK) begin
            sched_disp_chunk = 0;
            sched_disp_frame = (sched_disp_frame + 1) % 65536;
          end
        end
        nxt = frame + 1;
      end else begin
        sched_shown[slot][chunk] = 1'b1;
        if (frame + 1 == sched_frame_total && chunk == NCHUNK - 1) begin
          for (int w = 0; w < sched_workers; w++) add_task(KIND_EXIT_WORKER, 0, 0);
          add_task(KIND_EXIT_DISPLAY, 0, 0);
          n_exits++;
        end
        nxt = frame + NBUF;
      end
      // Queue the next frame once its dependencies are complete
      prv = (nxt + NSLOT - 1) % NSLOT;
      back = (nxt + NBUF) % NSLOT;
      if (sched_render[prv] == ALL_CHUNKS && sched_shown[back] == ALL_CHUNKS &&
          nxt < sched_frame_total) begin
        sched_render[prv] = '0;
        sched_shown[back] = '0;
        add_render_frame(nxt);
      end
    end
    if (batch.size() == 0) begin
      t.kind = KIND_RENDER;
      t.frame = '0;
      t.chunk = '0;
      t.has_task = 1'b0;
      t.is_last = 1'b0;
      batch.push_back(t);
    end
    batch[batch.size()-1].is_last = 1'b1;
    foreach (batch[i]) begin
      due_tasks.push_back(batch[i]);
      // Open work the workers and the display will later report back
      if (batch[i].has_task && (ev.action != ACT_START || ev.tracked) &&
          (batch[i].kind == KIND_RENDER || batch[i].kind == KIND_DISPLAY)) begin
        job.action = (batch[i].kind == KIND_RENDER) ? ACT_RENDER_DONE : ACT_DISPLAY_DONE;
        job.frame = batch[i].frame;
        job.chunk = batch[i].chunk;
        job.tracked = 1'b1;
        open_jobs.push_back(job);
      end
    end
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_tasks(cur_event);
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          cur_event = event_queue.pop_front();
          in_action <= cur_event.action;
          in_frame_number <= cur_event.frame;
          in_chunk_index <= cur_event.chunk;
          in_valid <= 1'b1;
          gap_left = pick_gap(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!rx_calm && $urandom_range(0, 99) < 25)
        rx_stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
    end
  end

  // Result checker
  always @(posedge clk) begin
    sched_task_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (due_tasks.size() == 0) begin
        $display("%0t: unexpected result kind=%0d frame=%0d chunk=%0d valid=%0b last=%0b",
                 $time, out_task_kind, out_task_frame, out_task_chunk, out_task_valid,
                 out_last_task);
        n_fail++;
      end else begin
        want = due_tasks.pop_front();
        if (out_task_kind !== want.kind || out_task_frame !== want.frame ||
            out_task_chunk !== want.chunk || out_task_valid !== want.has_task ||
            out_last_task !== want.is_last) begin
          $display("%0t: task mismatch expected kind=%0d frame=%0d chunk=%0d valid=%0b last=%0b",
                   $time, want.kind, want.frame, want.chunk, want.has_task, want.is_last);
          $display("%0t:                 actual kind=%0d frame=%0d chunk=%0d valid=%0b last=%0b",
                   $time, out_task_kind, out_task_frame, out_task_chunk, out_task_valid,
                   out_last_task);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests pending and %0d results due",
               $time, event_queue.size(), due_tasks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_event(logic [1:0] action, logic [FRAME_W-1:0] frame,
                             logic [CHUNK_W-1:0] chunk, bit tracked);
    sched_event_t ev;
    ev.action = action;
    ev.frame = frame;
    ev.chunk = chunk;
    ev.tracked = tracked;
    event_queue.push_back(ev);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_TOTAL) sched_frame_total = int'(val);
    else if (idx == CFG_WORKER_COUNT) sched_workers = int'(val[WORKER_W-1:0]);
    n_cfg++;
  endtask

  // Hold until every request is taken and every task has come out
  task automatic drain();
    while (event_queue.size() != 0 || in_valid || due_tasks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Act as workers and display: report open jobs back, mixed with replays and noise
  task automatic run_flow(int budget);
    sched_event_t ev;
    int k, r, idx;
    k = 0;
    while (k < budget) begin
      @(negedge clk);
      if (event_queue.size() < 2) begin
        r = $urandom_range(0, 99);
        if (open_jobs.size() != 0 && r < 88) begin
          idx = (r < 50) ? 0 : $urandom_range(0, open_jobs.size() - 1);
          ev = open_jobs[idx];
          open_jobs.delete(idx);
          event_queue.push_back(ev);
          recent_events.push_back(ev);
          if (recent_events.size() > 12) void'(recent_events.pop_front());
          k++;
        end else if (open_jobs.size() != 0 || (event_queue.size() == 0 && !in_valid)) begin
          r = $urandom_range(0, 99);
          if (recent_events.size() == 0 && open_jobs.size() == 0) begin
            queue_event(ACT_START, '0, '0, 1'b1);
            k++;
          end else if (r < 45 && recent_events.size() != 0) begin
            // Replay a recent report to restart a stalled pipeline
            ev = recent_events[$urandom_range(0, recent_events.size() - 1)];
            event_queue.push_back(ev);
            k++;
          end else if (r < 94) begin
            ev.action = 2'($urandom_range(0, 3));
            ev.frame = FRAME_W'($urandom);
            ev.chunk = CHUNK_W'($urandom);
            ev.tracked = 1'b0;
            event_queue.push_back(ev);
            if (ev.action != ACT_UNKNOWN) k++;
          end else begin
            queue_event(ACT_START, FRAME_W'($urandom), CHUNK_W'($urandom), 1'b0);
            k++;
          end
        end
      end
    end
  endtask

  initial begin
    int total;
    for (int s = 0; s < NSLOT; s++) begin
      sched_render[s] = '0;
      sched_shown[s] = (s >= NBUF) ? ALL_CHUNKS : '0;
    end
    sched_disp_frame = 0;
    sched_disp_chunk = 0;
    sched_frame_total = 10;
    sched_workers = 4;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks at the reset settings
    queue_event(ACT_UNKNOWN, '0, '0, 1'b0);
    queue_event(ACT_UNKNOWN, '1, '1, 1'b0);
    queue_event(ACT_DISPLAY_DONE, 16'd9, 3'd7, 1'b0);
    queue_event(ACT_DISPLAY_DONE, '1, 3'd0, 1'b0);
    queue_event(ACT_RENDER_DONE, '1, 3'd7, 1'b0);
    queue_event(ACT_RENDER_DONE, '0, 3'd0, 1'b0);
    queue_event(ACT_START, '0, '0, 1'b1);
    queue_event(ACT_START, '1, '1, 1'b0);
    drain();

    // Short run with no workers, under a long result hold-off
    write_reg(CFG_FRAME_TOTAL, 16'd4);
    write_reg(CFG_WORKER_COUNT, 16'hFFF0);
    write_reg(CFG_SPARE_A, 16'hA5A5);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    queue_event(ACT_DISPLAY_DONE, 16'd3, 3'd7, 1'b0);
    rx_hold_reqs++;
    run_flow(60);
    drain();

    // Widest settings, back to back traffic
    write_reg(CFG_FRAME_TOTAL, 16'hFFFF);
    write_reg(CFG_WORKER_COUNT, 16'h000F);
    tx_burst = 1'b1;
    rx_calm = 1'b1;
    queue_event(ACT_DISPLAY_DONE, 16'hFFFE, 3'd7, 1'b0);
    run_flow(30);
    drain();
    tx_burst = 1'b0;
    rx_calm = 1'b0;

    // Zero frames: nothing may queue and exit never fires
    write_reg(CFG_FRAME_TOTAL, 16'd0);
    write_reg(CFG_WORKER_COUNT, 16'd1);
    queue_event(ACT_DISPLAY_DONE, '1, 3'd7, 1'b0);
    queue_event(ACT_DISPLAY_DONE, '0, 3'd7, 1'b0);
    run_flow(15);
    drain();

    // Let the pipeline run to an exit a few frames on
    total = peak_frame + 3;
    if (total > 65535) total = 65535;
    write_reg(CFG_FRAME_TOTAL, total[CFG_DATA_W-1:0]);
    write_reg(CFG_WORKER_COUNT, CFG_DATA_W'($urandom_range(2, 14)));
    run_flow(30);
    drain();

    $display("Covered %0d requests and %0d results over %0d register writes, %0d exit bursts.",
             n_requests, n_results, n_cfg, n_exits);
    if (n_fail == 0 && due_tasks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d results never seen", n_fail, due_tasks.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fcps_pkg.sv
rtl/fcps_datapath.sv
rtl/fcps_ctrl.sv
rtl/frame_chunk_pipeline_scheduler_top.sv
sim/frame_chunk_pipeline_scheduler_top_tb.sv
